[design/assert_macros.svh]
// assertion helpers for the design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AWT_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/awt_pkg.sv]
`default_nettype none
package awt_pkg;

    // slot index is the low bits of the sequence, so the window is a power of two
    localparam int unsigned Window   = 32;
    localparam int unsigned WinBits  = $clog2(Window);
    localparam int unsigned SeqW     = 32;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned MaskW    = 32;
    localparam int unsigned MaskBits = $clog2(MaskW);
    localparam int unsigned TimeoutW = 16;
    localparam int unsigned ShiftW   = 3;
    localparam int unsigned KindW    = 2;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 16;

    localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;
    localparam logic [ShiftW-1:0]   ShiftReset   = 3'd3;

    typedef enum logic [KindW-1:0] {
        KIND_HDR  = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_LOST = 2'd2,
        KIND_DONE = 2'd3
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TIMEOUT = 1'b0,
        CFG_SHIFT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOSS,
        S_SHDR,
        S_FOLD,
        S_WRD,
        S_WEVAL,
        S_WDEC,
        S_WUPD,
        S_WEMIT,
        S_RDONE
    } t_state;

    typedef struct packed {
        logic  in_ready;
        logic  fold;
        logic  walk_init;
        logic  walk_next;
        logic  walk_clear;
        logic  rd_slot;
        logic  eval;
        logic  rtt_first;
        logic  rtt_diff;
        logic  rtt_upd;
        logic  send_commit;
        logic  load_out;
        logic  out_from_walk;
        logic  out_last;
        t_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic op_send;
        logic send_busy;
        logic walk_valid;
        logic walk_last;
        logic acked;
        logic lost;
        logic rtt_known;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[design/awt_in_if.sv]
`default_nettype none
interface awt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [awt_pkg::TimeW-1:0]   now_ms;
    logic [awt_pkg::SeqW-1:0]    peer_seq;
    logic [awt_pkg::SeqW-1:0]    peer_ack;
    logic [awt_pkg::MaskW-1:0]   peer_ack_mask;

    modport source (
        output valid, operation, now_ms, peer_seq, peer_ack, peer_ack_mask,
        input  ready
    );
    modport sink (
        input  valid, operation, now_ms, peer_seq, peer_ack, peer_ack_mask,
        output ready
    );
endinterface
`default_nettype wire

[design/awt_out_if.sv]
`default_nettype none
interface awt_out_if;
    logic                        valid;
    logic                        ready;
    logic [awt_pkg::KindW-1:0]   result_kind;
    logic [awt_pkg::SeqW-1:0]    out_seq;
    logic [awt_pkg::SeqW-1:0]    out_ack;
    logic [awt_pkg::MaskW-1:0]   out_ack_mask;
    logic [awt_pkg::TimeW-1:0]   rtt_ms;
    logic                        last;

    modport source (
        output valid, result_kind, out_seq, out_ack, out_ack_mask, rtt_ms, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, out_seq, out_ack, out_ack_mask, rtt_ms, last,
        output ready
    );
endinterface
`default_nettype wire

[design/awt_dpath.sv]
`default_nettype none
module awt_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    awt_in_if.sink                             i_in,
    awt_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [awt_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [awt_pkg::CfgDataW-1:0]  i_cfg_data,
    input  wire awt_pkg::t_cmd                 i_cmd,
    output awt_pkg::t_status                   o_sts
);

    // configuration
    logic [awt_pkg::TimeoutW-1:0] r_timeout;
    logic [awt_pkg::ShiftW-1:0]   r_shift;

    // captured item
    logic [awt_pkg::TimeW-1:0]  r_in_now;
    logic [awt_pkg::SeqW-1:0]   r_in_pseq;
    logic [awt_pkg::SeqW-1:0]   r_in_pack;
    logic [awt_pkg::MaskW-1:0]  r_in_pmask;

    // tracker state
    logic [awt_pkg::SeqW-1:0]   r_local;
    logic [awt_pkg::SeqW-1:0]   r_newest;
    logic [awt_pkg::MaskW-1:0]  r_rmask;
    logic [awt_pkg::Window-1:0] r_pvalid;
    logic [awt_pkg::TimeW-1:0]  r_rtt;
    logic                       r_known;
    logic [awt_pkg::TimeW-1:0]  r_send_time [awt_pkg::Window];
    logic [awt_pkg::TimeW-1:0]  r_rdata;

    // walk
    logic [awt_pkg::SeqW-1:0]    r_wseq;
    logic [awt_pkg::WinBits-1:0] r_widx;
    logic [awt_pkg::TimeW-1:0]   r_elapsed;
    logic                        r_acked;
    logic signed [awt_pkg::TimeW:0] r_rdiff;

    // output register
    logic                        r_out_valid;
    awt_pkg::t_kind              r_out_kind;
    logic [awt_pkg::SeqW-1:0]    r_out_seq;
    logic [awt_pkg::SeqW-1:0]    r_out_ack;
    logic [awt_pkg::MaskW-1:0]   r_out_mask;
    logic [awt_pkg::TimeW-1:0]   r_out_rtt;
    logic                        r_out_last;

    logic                        accept;
    logic                        out_free;
    logic [awt_pkg::WinBits-1:0] lslot;
    logic [awt_pkg::WinBits-1:0] wslot;
    logic [awt_pkg::SeqW-1:0]    n_newest;
    logic [awt_pkg::MaskW-1:0]   n_rmask;
    logic [awt_pkg::SeqW-1:0]    d_up;
    logic [awt_pkg::SeqW-1:0]    d_dn;
    logic [awt_pkg::SeqW-1:0]    d_up_m1;
    logic [awt_pkg::SeqW-1:0]    d_dn_m1;
    logic [awt_pkg::SeqW-1:0]    ack_gap;
    logic [awt_pkg::SeqW-1:0]    ack_gap_m1;
    logic                        ack_hit;
    logic [awt_pkg::TimeW:0]     sh_diff;
    logic [awt_pkg::SeqW-1:0]    send_lost_seq;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign lslot    = r_local[awt_pkg::WinBits-1:0];
    assign wslot    = r_wseq[awt_pkg::WinBits-1:0];
    assign send_lost_seq = r_local - awt_pkg::SeqW'(awt_pkg::Window);

    assign i_in.ready = i_cmd.in_ready;

    assign o_sts.accept     = accept;
    assign o_sts.op_send    = i_in.operation;
    assign o_sts.send_busy  = r_pvalid[lslot];
    assign o_sts.walk_valid = r_pvalid[wslot];
    assign o_sts.walk_last  = (r_widx == awt_pkg::WinBits'(awt_pkg::Window - 1));
    assign o_sts.acked      = r_acked;
    assign o_sts.lost       = (r_elapsed > awt_pkg::TimeW'(r_timeout));
    assign o_sts.rtt_known  = r_known;
    assign o_sts.out_free   = out_free;

    // peer sequence fold
    always_comb begin
        d_up    = r_in_pseq - r_newest;
        d_dn    = r_newest - r_in_pseq;
        d_up_m1 = d_up - awt_pkg::SeqW'(1);
        d_dn_m1 = d_dn - awt_pkg::SeqW'(1);
        n_newest = r_newest;
        n_rmask  = r_rmask;
        if (r_in_pseq > r_newest) begin
            if (d_up >= awt_pkg::SeqW'(awt_pkg::MaskW)) begin
                n_rmask = '0;
            end else begin
                n_rmask = r_rmask << d_up[awt_pkg::MaskBits-1:0];
            end
            if (d_up <= awt_pkg::SeqW'(awt_pkg::MaskW)) begin
                n_rmask[d_up_m1[awt_pkg::MaskBits-1:0]] = 1'b1;
            end
            n_newest = r_in_pseq;
        end else if (r_in_pseq < r_newest) begin
            if (d_dn <= awt_pkg::SeqW'(awt_pkg::MaskW)) begin
                n_rmask[d_dn_m1[awt_pkg::MaskBits-1:0]] = 1'b1;
            end
        end
    end

    // ack test of the walked slot
    always_comb begin
        ack_gap    = r_in_pack - r_wseq;
        ack_gap_m1 = ack_gap - awt_pkg::SeqW'(1);
        ack_hit    = (r_wseq == r_in_pack)
                  || ((r_wseq < r_in_pack)
                      && (ack_gap <= awt_pkg::SeqW'(awt_pkg::MaskW))
                      && r_in_pmask[ack_gap_m1[awt_pkg::MaskBits-1:0]]);
    end

    assign sh_diff = r_rdiff >>> r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= awt_pkg::TimeoutReset;
            r_shift   <= awt_pkg::ShiftReset;
        end else if (i_cfg_we) begin
            case (awt_pkg::t_cfg_idx'(i_cfg_idx))
                awt_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                awt_pkg::CFG_SHIFT:   r_shift   <= i_cfg_data[awt_pkg::ShiftW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_now   <= i_in.now_ms;
            r_in_pseq  <= i_in.peer_seq;
            r_in_pack  <= i_in.peer_ack;
            r_in_pmask <= i_in.peer_ack_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local  <= '0;
            r_newest <= '0;
            r_rmask  <= '1;
            r_pvalid <= '0;
            r_rtt    <= '0;
            r_known  <= 1'b0;
        end else begin
            if (i_cmd.fold) begin
                r_newest <= n_newest;
                r_rmask  <= n_rmask;
            end
            if (i_cmd.send_commit) begin
                r_pvalid[lslot] <= 1'b1;
                r_local         <= r_local + awt_pkg::SeqW'(1);
            end
            if (i_cmd.walk_clear) begin
                r_pvalid[wslot] <= 1'b0;
            end
            if (i_cmd.rtt_first) begin
                r_rtt   <= r_elapsed;
                r_known <= 1'b1;
            end else if (i_cmd.rtt_upd) begin
                r_rtt <= r_rtt + sh_diff[awt_pkg::TimeW-1:0];
            end
        end
    end

    // send time store
    always_ff @(posedge i_clk) begin
        if (i_cmd.send_commit) begin
            r_send_time[lslot] <= r_in_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_slot) begin
            r_rdata <= r_send_time[wslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
        end else if (i_cmd.walk_init) begin
            r_widx <= '0;
        end else if (i_cmd.walk_next) begin
            r_widx <= r_widx + awt_pkg::WinBits'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_wseq <= r_local - awt_pkg::SeqW'(awt_pkg::Window);
        end else if (i_cmd.walk_next) begin
            r_wseq <= r_wseq + awt_pkg::SeqW'(1);
        end
        if (i_cmd.eval) begin
            r_elapsed <= r_in_now - r_rdata;
            r_acked   <= ack_hit;
        end
        if (i_cmd.rtt_diff) begin
            r_rdiff <= $signed({1'b0, r_elapsed}) - $signed({1'b0, r_rtt});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_rtt  <= r_rtt;
            r_out_last <= i_cmd.out_last;
            case (i_cmd.out_kind)
                awt_pkg::KIND_HDR: begin
                    r_out_seq  <= r_local;
                    r_out_ack  <= r_newest;
                    r_out_mask <= r_rmask;
                end
                awt_pkg::KIND_DONE: begin
                    r_out_seq  <= '0;
                    r_out_ack  <= r_newest;
                    r_out_mask <= r_rmask;
                end
                default: begin
                    r_out_seq  <= i_cmd.out_from_walk ? r_wseq : send_lost_seq;
                    r_out_ack  <= '0;
                    r_out_mask <= '0;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_out_kind;
    assign o_out.out_seq      = r_out_seq;
    assign o_out.out_ack      = r_out_ack;
    assign o_out.out_ack_mask = r_out_mask;
    assign o_out.rtt_ms       = r_out_rtt;
    assign o_out.last         = r_out_last;

endmodule
`default_nettype wire

[design/awt_ctrl.sv]
`default_nettype none
`include "assert_macros.svh"
module awt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire awt_pkg::t_status i_sts,
    output awt_pkg::t_cmd         o_cmd
);

    awt_pkg::t_state r_state;
    awt_pkg::t_state n_state;

    logic last_load;
    logic in_idle;

    assign last_load = o_cmd.load_out && o_cmd.out_last;
    assign in_idle   = (r_state == awt_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= awt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            awt_pkg::S_IDLE: begin
                o_cmd.in_ready = i_rst_n;
                if (i_sts.accept) begin
                    n_state = i_sts.op_send ? awt_pkg::S_SLOSS : awt_pkg::S_FOLD;
                end
            end
            // slot about to be reused still pending
            awt_pkg::S_SLOSS: begin
                if (!i_sts.send_busy) begin
                    n_state = awt_pkg::S_SHDR;
                end else if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = awt_pkg::KIND_LOST;
                    n_state        = awt_pkg::S_SHDR;
                end
            end
            awt_pkg::S_SHDR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out    = 1'b1;
                    o_cmd.out_kind    = awt_pkg::KIND_HDR;
                    o_cmd.out_last    = 1'b1;
                    o_cmd.send_commit = 1'b1;
                    n_state           = awt_pkg::S_IDLE;
                end
            end
            awt_pkg::S_FOLD: begin
                o_cmd.fold      = 1'b1;
                o_cmd.walk_init = 1'b1;
                n_state         = awt_pkg::S_WRD;
            end
            awt_pkg::S_WRD: begin
                if (i_sts.walk_valid) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = awt_pkg::S_WEVAL;
                end else begin
                    o_cmd.walk_next = 1'b1;
                    if (i_sts.walk_last) begin
                        n_state = awt_pkg::S_RDONE;
                    end
                end
            end
            awt_pkg::S_WEVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = awt_pkg::S_WDEC;
            end
            awt_pkg::S_WDEC: begin
                if (i_sts.acked) begin
                    if (!i_sts.rtt_known) begin
                        o_cmd.rtt_first = 1'b1;
                        n_state         = awt_pkg::S_WEMIT;
                    end else begin
                        o_cmd.rtt_diff = 1'b1;
                        n_state        = awt_pkg::S_WUPD;
                    end
                end else if (i_sts.lost) begin
                    n_state = awt_pkg::S_WEMIT;
                end else begin
                    o_cmd.walk_next = 1'b1;
                    n_state = i_sts.walk_last ? awt_pkg::S_RDONE : awt_pkg::S_WRD;
                end
            end
            awt_pkg::S_WUPD: begin
                o_cmd.rtt_upd = 1'b1;
                n_state       = awt_pkg::S_WEMIT;
            end
            awt_pkg::S_WEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out      = 1'b1;
                    o_cmd.out_from_walk = 1'b1;
                    o_cmd.out_kind      = i_sts.acked ? awt_pkg::KIND_ACK
                                                      : awt_pkg::KIND_LOST;
                    o_cmd.walk_clear    = 1'b1;
                    o_cmd.walk_next     = 1'b1;
                    n_state = i_sts.walk_last ? awt_pkg::S_RDONE : awt_pkg::S_WRD;
                end
            end
            awt_pkg::S_RDONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = awt_pkg::KIND_DONE;
                    o_cmd.out_last = 1'b1;
                    n_state        = awt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = awt_pkg::S_IDLE;
            end
        endcase
    end

    `AWT_ASSERT(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free, "load while full")
    `AWT_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, last_load, in_idle, "no return to idle")
    `AWT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_sts.accept, !in_idle, "item not started")

endmodule
`default_nettype wire

[design/ack_window_tracker.sv]
// acknowledgement engine for reliable datagrams
// i_in: valid/ready channel of items; operation 1 = packet sent, 0 = header received
// o_out: valid/ready channel of results; last marks the final result of an item
// i_cfg_we/i_cfg_idx/i_cfg_data: register writes (0 loss timeout, 1 rtt shift),
//   only while idle
// a send gives an optional lost report for the reused slot and the outgoing header
// a receive folds the peer sequence (state S_FOLD), then walks the 32 window slots
//   one after another: a free slot is skipped; a pending slot is read and evaluated,
//   then kept, reported lost, or reported acknowledged after the rtt update; the
//   receive-done result ends the item
// the walk through the window slots, sharing one send-time memory port and one
//   rtt adder, sets the item rate
// a one-entry output register holds the result; the next item is taken while the
//   final result still waits, and a stalled receiver holds the walk at its next result
// reset (synchronous, active low) clears sequences and rtt, sets the received mask
//   to all ones, frees every slot and restores the register defaults; no item is
//   taken while reset is held
`default_nettype none
module ack_window_tracker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    awt_in_if.sink                             i_in,
    awt_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [awt_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [awt_pkg::CfgDataW-1:0]  i_cfg_data
);

    awt_pkg::t_cmd    cmd;
    awt_pkg::t_status sts;

    awt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    awt_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

    localparam int DrainCycles = 200;
    localparam int HoldCycles  = 400;

    typedef struct packed {
        awt_pkg::t_kind                kind;
        logic [awt_pkg::SeqW-1:0]      seq;
        logic [awt_pkg::SeqW-1:0]      ack;
        logic [awt_pkg::MaskW-1:0]     mask;
        logic [awt_pkg::TimeW-1:0]     rtt;
        logic                          last;
    } t_tracker_result;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_cfg_we   = 1'b0;
    logic [awt_pkg::CfgIdxW-1:0]  i_cfg_idx  = '0;
    logic [awt_pkg::CfgDataW-1:0] i_cfg_data = '0;
    logic                         rx_ready   = 1'b0;
    bit                           rx_steady  = 1'b0;
    bit                           tx_steady  = 1'b0;
    int                           hold_len   = 0;
    int                           hold_left  = 0;
    int                           errors     = 0;
    logic [awt_pkg::TimeW-1:0]    clock_ms;

    // tracker state as the block should hold it
    logic [awt_pkg::SeqW-1:0]     next_seq;
    logic [awt_pkg::SeqW-1:0]     peer_newest;
    logic [awt_pkg::MaskW-1:0]    peer_mask;
    logic                         slot_busy [awt_pkg::Window];
    logic [awt_pkg::TimeW-1:0]    slot_time [awt_pkg::Window];
    logic [awt_pkg::TimeW-1:0]    rtt_est;
    logic                         rtt_seen;
    logic [awt_pkg::TimeoutW-1:0] cfg_timeout;
    logic [awt_pkg::ShiftW-1:0]   cfg_shift;

    t_tracker_result              tracker_results [$];

    awt_in_if  in_if ();
    awt_out_if out_if ();

    assign out_if.ready = rx_ready;

    ack_window_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 200) begin
            $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        end
    endtask

    task automatic reset_tracker();
        next_seq    = '0;
        peer_newest = '0;
        peer_mask   = '1;
        rtt_est     = '0;
        rtt_seen    = 1'b0;
        cfg_timeout = awt_pkg::TimeoutReset;
        cfg_shift   = awt_pkg::ShiftReset;
        for (int i = 0; i < awt_pkg::Window; i++) begin
            slot_busy[i] = 1'b0;
            slot_time[i] = '0;
        end
    endtask

    task automatic push_result(awt_pkg::t_kind kind, logic [awt_pkg::SeqW-1:0] seq,
                               logic [awt_pkg::SeqW-1:0] ack,
                               logic [awt_pkg::MaskW-1:0] mask, logic last);
        t_tracker_result r;
        r.kind = kind;
        r.seq  = seq;
        r.ack  = ack;
        r.mask = mask;
        r.rtt  = rtt_est;
        r.last = last;
        tracker_results = {tracker_results, r};
    endtask

    task automatic fold_peer(logic [awt_pkg::SeqW-1:0] pseq);
        logic [awt_pkg::SeqW-1:0] span;
        if (pseq > peer_newest) begin
            span = pseq - peer_newest;
            if (span >= 32) peer_mask = '0;
            else peer_mask = peer_mask << span;
            if (span <= 32) peer_mask = peer_mask | (32'h1 << (span - 1));
            peer_newest = pseq;
        end else if (pseq < peer_newest) begin
            span = peer_newest - pseq;
            if (span <= 32) peer_mask = peer_mask | (32'h1 << (span - 1));
        end
    endtask

    function automatic bit acked_by(logic [awt_pkg::SeqW-1:0] seq,
                                    logic [awt_pkg::SeqW-1:0] pack,
                                    logic [awt_pkg::MaskW-1:0] pmask);
        if (seq == pack) return 1'b1;
        if (seq < pack && (pack - seq) <= 32) return pmask[pack - seq - 1];
        return 1'b0;
    endfunction

    task automatic smooth_rtt(logic [awt_pkg::TimeW-1:0] sample_ms);
        logic [awt_pkg::TimeW:0] gap;
        if (!rtt_seen) begin
            rtt_est  = sample_ms;
            rtt_seen = 1'b1;
        end else if (sample_ms >= rtt_est) begin
            rtt_est = rtt_est + ((sample_ms - rtt_est) >> cfg_shift);
        end else begin
            gap     = {1'b0, rtt_est - sample_ms} + (33'd1 << cfg_shift) - 33'd1;
            rtt_est = rtt_est - awt_pkg::TimeW'(gap >> cfg_shift);
        end
    endtask

    task automatic advance_tracker(logic op, logic [awt_pkg::TimeW-1:0] now_ms,
                                   logic [awt_pkg::SeqW-1:0] pseq,
                                   logic [awt_pkg::SeqW-1:0] pack,
                                   logic [awt_pkg::MaskW-1:0] pmask);
        logic [awt_pkg::SeqW-1:0]    newest;
        logic [awt_pkg::SeqW-1:0]    seq;
        logic [awt_pkg::TimeW-1:0]   elapsed;
        logic [awt_pkg::WinBits-1:0] slot;
        if (op) begin
            slot = next_seq[awt_pkg::WinBits-1:0];
            if (slot_busy[slot]) begin
                push_result(awt_pkg::KIND_LOST, next_seq - awt_pkg::Window, '0, '0, 1'b0);
            end
            push_result(awt_pkg::KIND_HDR, next_seq, peer_newest, peer_mask, 1'b1);
            slot_busy[slot] = 1'b1;
            slot_time[slot] = now_ms;
            next_seq        = next_seq + 1;
        end else begin
            fold_peer(pseq);
            newest = next_seq - 1;
            // oldest slot first
            for (int k = awt_pkg::Window - 1; k >= 0; k--) begin
                seq  = newest - k;
                slot = seq[awt_pkg::WinBits-1:0];
                if (slot_busy[slot]) begin
                    elapsed = now_ms - slot_time[slot];
                    if (acked_by(seq, pack, pmask)) begin
                        smooth_rtt(elapsed);
                        slot_busy[slot] = 1'b0;
                        push_result(awt_pkg::KIND_ACK, seq, '0, '0, 1'b0);
                    end else if (elapsed > {16'h0, cfg_timeout}) begin
                        slot_busy[slot] = 1'b0;
                        push_result(awt_pkg::KIND_LOST, seq, '0, '0, 1'b0);
                    end
                end
            end
            push_result(awt_pkg::KIND_DONE, '0, peer_newest, peer_mask, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_tracker_result want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready) begin
            if (tracker_results.size() == 0) begin
                report_mismatch("result with nothing expected", out_if.out_seq, '0);
            end else begin
                want = tracker_results.pop_front();
                if (out_if.result_kind !== want.kind)
                    report_mismatch("result_kind", 32'(out_if.result_kind), 32'(want.kind));
                if (out_if.out_seq !== want.seq)
                    report_mismatch("out_seq", out_if.out_seq, want.seq);
                if (out_if.out_ack !== want.ack)
                    report_mismatch("out_ack", out_if.out_ack, want.ack);
                if (out_if.out_ack_mask !== want.mask)
                    report_mismatch("out_ack_mask", out_if.out_ack_mask, want.mask);
                if (out_if.rtt_ms !== want.rtt)
                    report_mismatch("rtt_ms", out_if.rtt_ms, want.rtt);
                if (out_if.last !== want.last)
                    report_mismatch("last", 32'(out_if.last), 32'(want.last));
            end
        end
    end

    // receiver: random stalls, steady stretches and long hold-offs
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_ready <= 1'b0;
        end else if (rx_steady) begin
            rx_ready <= 1'b1;
        end else begin
            rx_ready <= ($urandom_range(99) >= 23);
        end
    end

    task automatic send_item(logic op, logic [awt_pkg::TimeW-1:0] now_ms,
                             logic [awt_pkg::SeqW-1:0] pseq,
                             logic [awt_pkg::SeqW-1:0] pack,
                             logic [awt_pkg::MaskW-1:0] pmask);
        while (!tx_steady && $urandom_range(99) < 23) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= op;
        in_if.now_ms        <= now_ms;
        in_if.peer_seq      <= pseq;
        in_if.peer_ack      <= pack;
        in_if.peer_ack_mask <= pmask;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        advance_tracker(op, now_ms, pseq, pack, pmask);
        @(negedge i_clk);
    endtask

    task automatic send_pkt(logic [awt_pkg::TimeW-1:0] now_ms);
        send_item(1'b1, now_ms, $urandom, $urandom, $urandom);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (tracker_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(awt_pkg::t_cfg_idx idx, logic [awt_pkg::CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == awt_pkg::CFG_TIMEOUT) cfg_timeout = data[awt_pkg::TimeoutW-1:0];
        else cfg_shift = data[awt_pkg::ShiftW-1:0];
    endtask

    task automatic configure(logic [awt_pkg::TimeoutW-1:0] timeout_ms,
                             logic [awt_pkg::ShiftW-1:0] shift);
        drain_results();
        repeat (DrainCycles) @(negedge i_clk);
        cfg_write(awt_pkg::CFG_TIMEOUT, awt_pkg::CfgDataW'(timeout_ms));
        cfg_write(awt_pkg::CFG_SHIFT, awt_pkg::CfgDataW'(shift));
    endtask

    task automatic set_steady(bit on);
        @(posedge i_clk);
        tx_steady = on;
        rx_steady = on;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        // duplicate of the newest peer sequence with nothing pending
        send_item(1'b0, 32'd0, 32'd0, 32'd0, 32'h0);
        send_pkt(32'd100);
        send_pkt(32'd110);
        // one by ack, one by mask; second sample lowers the rtt
        send_item(1'b0, 32'd150, 32'd5, 32'd1, 32'h0000_0001);
        send_item(1'b0, 32'd150, 32'd3, 32'd0, 32'h0);
        // newer by 33 clears the mask, newer by exactly 32 keeps one bit
        send_item(1'b0, 32'd150, 32'd38, 32'd0, 32'h0);
        send_item(1'b0, 32'd150, 32'd70, 32'd0, 32'h0);
        // older by exactly 32, then by 33
        send_item(1'b0, 32'd150, 32'd38, 32'd0, 32'h0);
        send_item(1'b0, 32'd150, 32'd37, 32'd0, 32'h0);
        send_pkt(32'd200);
        send_pkt(32'd200);
        // 32 below the ack with the top mask bit, then 33 below, then above the ack
        send_item(1'b0, 32'd200, 32'd70, 32'd34, 32'h8000_0000);
        send_item(1'b0, 32'd200, 32'd70, 32'd36, 32'hFFFF_FFFF);
        send_item(1'b0, 32'd200, 32'd70, 32'd2, 32'hFFFF_FFFF);
        // elapsed equal to the timeout is kept, one more is lost
        send_item(1'b0, 32'd1200, 32'd70, 32'd0, 32'h0);
        send_item(1'b0, 32'd1201, 32'd70, 32'd0, 32'h0);
        configure(16'd0, 3'd0);
        send_pkt(32'd1300);
        send_item(1'b0, 32'd1300, 32'd70, 32'd0, 32'h0);
        send_item(1'b0, 32'd1301, 32'd70, 32'd0, 32'h0);
        send_pkt(32'd1400);
        send_item(1'b0, 32'd1420, 32'd71, 32'd5, 32'h0);
        configure(16'd0, 3'd7);
        send_pkt(32'd1500);
        send_item(1'b0, 32'd2000, 32'd72, 32'd6, 32'h0);
        // time wrap between send and ack
        configure(16'hFFFF, 3'd3);
        send_pkt(32'hFFFF_FFF0);
        send_item(1'b0, 32'h0000_0010, 32'd73, 32'd7, 32'h0);
    endtask

    task automatic test_backpressure();
        configure(16'hFFFF, 3'd3);
        clock_ms = 32'd5000;
        @(posedge i_clk);
        hold_len = HoldCycles;
        @(negedge i_clk);
        // more sends than slots, so the oldest are overwritten
        repeat (40) begin
            send_pkt(clock_ms);
            clock_ms = clock_ms + 3;
        end
        // acknowledges every slot at once
        send_item(1'b0, clock_ms, peer_newest + 1, next_seq - 1, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic random_item();
        int                        pick;
        logic [awt_pkg::SeqW-1:0]  pseq;
        logic [awt_pkg::MaskW-1:0] pmask;
        pick     = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(0, 40);
        if (pick < 15) begin
            send_item(1'($urandom_range(1)), $urandom_range(1) ? $urandom : clock_ms,
                      $urandom, $urandom, $urandom);
        end else if (pick < 55) begin
            send_pkt(clock_ms);
        end else begin
            case ($urandom_range(4))
                0: pseq = peer_newest - $urandom_range(0, 34);
                1: pseq = peer_newest + $urandom_range(4, 40);
                default: pseq = peer_newest + $urandom_range(1, 3);
            endcase
            pmask = $urandom_range(1) ? ($urandom | $urandom) : $urandom;
            send_item(1'b0, clock_ms, pseq, next_seq - 1 - $urandom_range(0, 6), pmask);
        end
    endtask

    task automatic test_random();
        clock_ms = $urandom;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: configure(16'd1000, 3'd3);
                1: configure(16'd0, 3'd0);
                2: configure(16'hFFFF, 3'd7);
                default: configure(16'($urandom_range(20, 300)), 3'($urandom_range(7)));
            endcase
            if (p == 1) set_steady(1'b1);
            repeat (35) begin
                random_item();
                if ($urandom_range(99) < 4) drain_results();
            end
            if (p == 1) set_steady(1'b0);
        end
    endtask

    task automatic test_field_extremes();
        send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h0, 32'hFFFF_FFFE, next_seq - 1, 32'h0);
    endtask

    initial begin
        in_if.valid         = 1'b0;
        in_if.operation     = 1'b0;
        in_if.now_ms        = '0;
        in_if.peer_seq      = '0;
        in_if.peer_ack      = '0;
        in_if.peer_ack_mask = '0;
        clock_ms            = '0;
        reset_tracker();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        test_field_extremes();
        drain_results();
        repeat (DrainCycles) @(negedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/awt_pkg.sv
design/awt_in_if.sv
design/awt_out_if.sv
design/awt_dpath.sv
design/awt_ctrl.sv
design/ack_window_tracker.sv
tb/tb_top.sv
